FILE: rtl/fcp_pkg.sv
// Shared types, character codes, result codes and the note color table
// for the framed command parser. Used by every module of the block.
package fcp_pkg;

    // Message layout
    localparam logic [3:0] MSG_LEN   = 4'd11;
    localparam logic [3:0] POS_START = 4'd0;
    localparam logic [3:0] POS_CMD   = 4'd1;
    localparam logic [3:0] POS_NOTE  = 4'd2;
    localparam logic [3:0] POS_NUM   = 4'd3;
    localparam logic [3:0] POS_END   = 4'd10;

    // Character codes
    localparam logic [7:0] CH_FRAME_START = 8'h25;  // '%'
    localparam logic [7:0] CH_FRAME_END   = 8'h26;  // '&'
    localparam logic [7:0] CH_PLUS        = 8'h2B;  // '+'
    localparam logic [7:0] CH_MINUS       = 8'h2D;  // '-'
    localparam logic [7:0] CH_ZERO        = 8'h30;  // '0'
    localparam logic [7:0] CH_ONE         = 8'h31;  // '1'
    localparam logic [7:0] CH_TWO         = 8'h32;  // '2'
    localparam logic [7:0] CH_NINE        = 8'h39;  // '9'
    localparam logic [7:0] CH_SPACE       = 8'h20;
    localparam logic [7:0] CH_TAB         = 8'h09;
    localparam logic [7:0] CH_CR          = 8'h0D;
    localparam logic [7:0] CH_NUL         = 8'h00;

    // Result status codes
    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_BAD_FRAME = 3'd1;
    localparam logic [2:0] STATUS_BAD_CMD   = 3'd2;
    localparam logic [2:0] STATUS_BAD_NUM   = 3'd3;
    localparam logic [2:0] STATUS_BAD_NOTE  = 3'd4;

    // Command codes
    localparam logic [1:0] CMD_OFF   = 2'd0;
    localparam logic [1:0] CMD_DRONE = 2'd1;
    localparam logic [1:0] CMD_NOTE  = 2'd2;

    // Highest valid note index
    localparam logic [7:0] NOTE_LAST = 8'd11;

    // Width of the decoded magnitude: at most seven digits reach the judge.
    localparam int MAG_W = 24;

    // Input word
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       burst_end;
    } rx_word_t;

    // Result word
    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  command;
        logic [23:0] note_color;
        logic [31:0] duration_us;
    } result_word_t;

    // Summary of one finished burst, handed from the collector to the judge
    typedef struct packed {
        logic             frame_ok;
        logic [7:0]       sel;
        logic [7:0]       note;
        logic             num_ok;
        logic             neg;
        logic [MAG_W-1:0] mag;
    } fcp_snap_t;

    // Note color table
    function automatic logic [23:0] note_color_lookup(input logic [3:0] idx);
        logic [23:0] color;
        case (idx)
            4'd0:    color = 24'hFF0000;
            4'd1:    color = 24'hCE9AFF;
            4'd2:    color = 24'hFFFF00;
            4'd3:    color = 24'h656599;
            4'd4:    color = 24'hE3FBFF;
            4'd5:    color = 24'hAC1C00;
            4'd6:    color = 24'h00CCFF;
            4'd7:    color = 24'hFF6500;
            4'd8:    color = 24'hFF00FF;
            4'd9:    color = 24'h33CC33;
            4'd10:   color = 24'h8C8A8C;
            4'd11:   color = 24'h0000FE;
            default: color = 24'h000000;
        endcase
        return color;
    endfunction

endpackage

FILE: rtl/fcp_collect.sv
// Byte collector: keeps the bytes of a burst that the verdict needs and
// decodes the duration text one byte per word. Depends on fcp_pkg.
module fcp_collect
    import fcp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_stall,
    input  rx_word_t  byte_word,
    output logic      snap_valid,
    input  logic      snap_take,
    output fcp_snap_t snap
);

    typedef enum logic [1:0] {
        PH_SPACE,
        PH_SIGN,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_end(input logic [7:0] c);
        return (c == CH_NUL) || (c == CH_FRAME_END);
    endfunction

    logic [3:0]       cnt_reg, cnt_next;
    logic [7:0]       b0_reg, b0_next;
    logic [7:0]       b1_reg, b1_next;
    logic [7:0]       b2_reg, b2_next;
    logic [7:0]       b10_reg, b10_next;
    logic             b3end_reg, b3end_next;
    phase_t           phase_reg, phase_next;
    logic             ok_reg, ok_next;
    logic             neg_reg, neg_next;
    logic [MAG_W-1:0] mag_reg, mag_next;
    logic             snap_valid_reg, snap_valid_next;
    fcp_snap_t        snap_reg, snap_next;

    logic             accept;
    logic             last;
    logic [7:0]       b;
    logic             b3end_cur;
    logic [MAG_W-1:0] digit_ext;
    logic [MAG_W-1:0] mag_step;

    // A closing word needs a free summary slot; other words always enter.
    assign byte_stall = snap_valid_reg && !snap_take && last;
    assign accept     = byte_valid && !byte_stall;
    assign last       = byte_word.burst_end;
    assign b          = byte_word.rx_byte;

    // Multiply by ten with shifts and add the new digit.
    assign digit_ext = {{(MAG_W-4){1'b0}}, b[3:0]};
    assign mag_step  = {mag_reg[MAG_W-4:0], 3'b000} + {mag_reg[MAG_W-2:0], 1'b0} + digit_ext;

    assign b3end_cur = (cnt_reg == POS_NUM) ? is_end(b) : b3end_reg;

    // Next state of the collector and the duration parser.
    always_comb
    begin
        cnt_next        = cnt_reg;
        b0_next         = b0_reg;
        b1_next         = b1_reg;
        b2_next         = b2_reg;
        b10_next        = b10_reg;
        b3end_next      = b3end_reg;
        phase_next      = phase_reg;
        ok_next         = ok_reg;
        neg_next        = neg_reg;
        mag_next        = mag_reg;
        snap_next       = snap_reg;
        snap_valid_next = snap_valid_reg;

        if (snap_take)
        begin
            snap_valid_next = 1'b0;
        end

        if (accept && (cnt_reg < MSG_LEN))
        begin
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == POS_START)
            begin
                b0_next = b;
            end
            if (cnt_reg == POS_CMD)
            begin
                b1_next = b;
            end
            if (cnt_reg == POS_NOTE)
            begin
                b2_next = b;
            end
            if (cnt_reg == POS_END)
            begin
                b10_next = b;
            end
            if (cnt_reg == POS_NUM)
            begin
                b3end_next = is_end(b);
            end

            // Duration text runs from byte 3 through byte 10.
            if (cnt_reg >= POS_NUM)
            begin
                unique case (phase_reg)
                    PH_SPACE:
                    begin
                        if (is_space(b))
                        begin
                            phase_next = PH_SPACE;
                        end
                        else if ((b == CH_PLUS) || (b == CH_MINUS))
                        begin
                            phase_next = PH_SIGN;
                            neg_next   = (b == CH_MINUS);
                        end
                        else if (is_digit(b))
                        begin
                            phase_next = PH_DIGITS;
                            mag_next   = digit_ext;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                            ok_next    = b3end_cur;
                        end
                    end
                    PH_SIGN:
                    begin
                        if (is_digit(b))
                        begin
                            phase_next = PH_DIGITS;
                            mag_next   = digit_ext;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                            ok_next    = b3end_cur;
                        end
                    end
                    PH_DIGITS:
                    begin
                        if (is_digit(b))
                        begin
                            mag_next = mag_step;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                            ok_next    = is_end(b);
                        end
                    end
                    PH_DONE:
                    begin
                        phase_next = PH_DONE;
                    end
                    default:
                    begin
                        phase_next = PH_DONE;
                    end
                endcase
            end
        end

        // Summary of the burst, including the closing word itself.
        snap_next.frame_ok = (b0_next == CH_FRAME_START) && (b10_next == CH_FRAME_END);
        snap_next.sel      = b1_next;
        snap_next.note     = b2_next;
        snap_next.neg      = neg_next;
        snap_next.mag      = mag_next;
        unique case (phase_next)
            PH_DONE:   snap_next.num_ok = ok_next;
            PH_DIGITS: snap_next.num_ok = 1'b0;
            default:   snap_next.num_ok = b3end_next;
        endcase

        // A closing word hands over the summary and clears for the next burst.
        if (accept && last)
        begin
            snap_valid_next = 1'b1;
            cnt_next        = 4'd0;
            b0_next         = 8'd0;
            b1_next         = 8'd0;
            b2_next         = 8'd0;
            b10_next        = 8'd0;
            b3end_next      = 1'b0;
            phase_next      = PH_SPACE;
            ok_next         = 1'b0;
            neg_next        = 1'b0;
            mag_next        = '0;
        end
        else
        begin
            snap_next = snap_reg;
        end
    end

    // Collector state and summary register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= 4'd0;
            b0_reg         <= 8'd0;
            b1_reg         <= 8'd0;
            b2_reg         <= 8'd0;
            b10_reg        <= 8'd0;
            b3end_reg      <= 1'b0;
            phase_reg      <= PH_SPACE;
            ok_reg         <= 1'b0;
            neg_reg        <= 1'b0;
            mag_reg        <= '0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg        <= cnt_next;
            b0_reg         <= b0_next;
            b1_reg         <= b1_next;
            b2_reg         <= b2_next;
            b10_reg        <= b10_next;
            b3end_reg      <= b3end_next;
            phase_reg      <= phase_next;
            ok_reg         <= ok_next;
            neg_reg        <= neg_next;
            mag_reg        <= mag_next;
            snap_valid_reg <= snap_valid_next;
        end
    end

    // The summary payload needs no reset.
    always_ff @(posedge clk)
    begin
        snap_reg <= snap_next;
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

    // The kept byte count never passes the message length.
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= MSG_LEN)
        else $error("byte count beyond message length");

    // A closing word leaves the collector cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid && !byte_stall && byte_word.burst_end)
        |=> (cnt_reg == 4'd0) && (phase_reg == PH_SPACE) && snap_valid_reg)
        else $error("collector not cleared after burst end");

    // A new summary only appears after a closing word.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(snap_valid_reg) |-> $past(byte_valid && !byte_stall && byte_word.burst_end))
        else $error("summary without a closing word");

endmodule

FILE: rtl/fcp_judge.sv
// Verdict stage: turns a burst summary into one result word and holds it
// in the output register. Depends on fcp_pkg.
module fcp_judge
    import fcp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         snap_valid,
    output logic         snap_take,
    input  fcp_snap_t    snap,
    output logic         result_valid,
    input  logic         result_stall,
    output result_word_t result
);

    logic         out_valid_reg, out_valid_next;
    result_word_t out_reg, out_next;
    logic [31:0]  mag_ext;

    // The output register can take a new summary when empty or draining.
    assign snap_take = !out_valid_reg || !result_stall;

    assign mag_ext = {{(32-MAG_W){1'b0}}, snap.mag};

    // Checks in order: frame, command, number, note index.
    always_comb
    begin
        out_next             = '0;
        out_next.status      = STATUS_OK;
        out_next.command     = CMD_OFF;
        if (!snap.frame_ok)
        begin
            out_next.status = STATUS_BAD_FRAME;
        end
        else
        begin
            unique case (snap.sel)
                CH_ZERO:
                begin
                    out_next.command = CMD_OFF;
                end
                CH_ONE:
                begin
                    out_next.command = CMD_DRONE;
                end
                CH_TWO:
                begin
                    if (!snap.num_ok)
                    begin
                        out_next.status = STATUS_BAD_NUM;
                    end
                    else if (snap.note > NOTE_LAST)
                    begin
                        out_next.status = STATUS_BAD_NOTE;
                    end
                    else
                    begin
                        out_next.command     = CMD_NOTE;
                        out_next.note_color  = note_color_lookup(snap.note[3:0]);
                        out_next.duration_us = snap.neg ? (32'd0 - mag_ext) : mag_ext;
                    end
                end
                default:
                begin
                    out_next.status = STATUS_BAD_CMD;
                end
            endcase
        end
    end

    // Output valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (snap_take)
        begin
            out_valid_next = snap_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload loads whenever a summary moves in.
    always_ff @(posedge clk)
    begin
        if (snap_take && snap_valid)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // A rejected message carries no command, color or duration.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.status != STATUS_OK))
        |-> (out_reg.command == CMD_OFF) && (out_reg.note_color == 24'd0)
            && (out_reg.duration_us == 32'd0))
        else $error("rejected result carries payload");

    // Only a note carries a color or a duration.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.command != CMD_NOTE))
        |-> (out_reg.note_color == 24'd0) && (out_reg.duration_us == 32'd0))
        else $error("non-note result carries note data");

    // Status stays within the defined codes.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.status <= STATUS_BAD_NOTE))
        else $error("undefined status code");

endmodule

FILE: rtl/framed_command_parser.sv
// Framed command parser, top level: byte collector followed by the verdict
// stage. Depends on fcp_pkg, fcp_collect and fcp_judge.
//
// Usage: received bytes enter on the byte channel (byte_valid, byte_stall,
// byte_word), one word per cycle, each with a flag that marks the end of a
// burst. The first eleven bytes of a burst are kept; later ones are dropped.
// The word that closes a burst yields one result word on the result channel
// (result_valid, result_stall, result): a status, the command, the note
// color and the decoded duration. Other words yield nothing.
// Throughput is one byte word per cycle unless a closing word is stalled;
// the duration text is decoded on the fly, one digit step per byte, so
// no burst-end work is left over. A closing word passes two register
// stages (summary register, then output register) before its result is
// valid; a stalled output register keeps the summary waiting behind it.
// Reset clears the kept bytes, the count and both stage valid flags; the
// block is ready for a new burst in the first cycle after reset.
// When the receiver stalls, the result word holds and one further burst
// summary can wait behind it; non-closing bytes keep flowing in, and only
// a closing word is stalled while both slots are full.
module framed_command_parser
    import fcp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         byte_valid,
    output logic         byte_stall,
    input  rx_word_t     byte_word,
    output logic         result_valid,
    input  logic         result_stall,
    output result_word_t result
);

    logic      snap_valid;
    logic      snap_take;
    fcp_snap_t snap;

    fcp_collect u_collect (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_word  (byte_word),
        .snap_valid (snap_valid),
        .snap_take  (snap_take),
        .snap       (snap)
    );

    fcp_judge u_judge (
        .clk          (clk),
        .rst_n        (rst_n),
        .snap_valid   (snap_valid),
        .snap_take    (snap_take),
        .snap         (snap),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
